/* hdl/ncf_pkg.sv */
// ----------------------------------------------------------------------------
// ncf_pkg: shared definitions for the negative cycle finder
// Field widths, default sizes, the register map, the controller state codes
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ncf_pkg;

    // Default sizes handed to the top level parameters.
    localparam int MAX_VERTICES_DEF = 32;
    localparam int MAX_EDGES_DEF    = 1024;
    localparam int DIST_WIDTH_DEF   = 48;

    // Fixed field widths of the item channels.
    localparam int VERTEX_W = 5;
    localparam int WEIGHT_W = 18;
    localparam int VCOUNT_W = 6;
    localparam int EDGE_W   = 2 * VERTEX_W + WEIGHT_W;

    // A weight of this magnitude or more marks a missing edge.
    localparam int MISSING_LIMIT = 100000;

    // Reset value of the vertex count register.
    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 6'd32;

    // Register port: one 32-bit register at byte address 0.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_VERTEX_COUNT = 1'b0;

    // Controller states, one-hot.
    typedef enum logic [14:0] {
        ST_IDLE       = 15'h0001,
        ST_START      = 15'h0002,
        ST_EDGE_RD    = 15'h0004,
        ST_EDGE_DEC   = 15'h0008,
        ST_EDGE_ADD   = 15'h0010,
        ST_EDGE_CMP   = 15'h0020,
        ST_WALK_RD    = 15'h0040,
        ST_WALK_STEP  = 15'h0080,
        ST_COL_RD     = 15'h0100,
        ST_COL_CHK    = 15'h0200,
        ST_EMIT_FIRST = 15'h0400,
        ST_BUF_RD     = 15'h0800,
        ST_BUF_OUT    = 15'h1000,
        ST_EMIT_END   = 15'h2000,
        ST_EMIT_NONE  = 15'h4000
    } ncf_state_t;

    // Which result item the output register takes.
    typedef enum logic [1:0] {
        OUT_START = 2'd0,
        OUT_BUF   = 2'd1,
        OUT_CLOSE = 2'd2,
        OUT_NONE  = 2'd3
    } ncf_out_kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic          load_edge;
        logic          run_init;
        logic          edge_next;
        logic          relax_write;
        logic          found_capture;
        logic          walk_step;
        logic          walk_close;
        logic          col_write;
        logic          col_next;
        logic          cnt_dec;
        logic          out_load;
        ncf_out_kind_t out_kind;
        logic          total_clear;
    } ncf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic total_zero;
        logic relax;
        logic last_edge;
        logic check_phase;
        logic walk_last;
        logic col_done;
        logic len_one;
        logic out_free;
    } ncf_status_t;

endpackage

/* hdl/negative_cycle_finder_unit.sv */
// ----------------------------------------------------------------------------
// negative_cycle_finder_unit: Bellman-Ford negative cycle search
// Stores directed weighted edges, then on the last edge runs the relaxation
// passes and a check pass, and delivers the vertices of a negative cycle or a not-found result.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    edge_source, edge_target,
//                                           edge_weight, edge_last
//   m_        out        m_valid/m_ready    cycle_found, cycle_vertex,
//                                           result_last
//   apb       in/out     psel/penable       vertex_count at byte address 0
//
// Edges are taken one per cycle while no search runs. The item with edge_last
// set starts a search: V relaxation passes for V vertices and a check pass
// over the E stored edges, one edge at a time through the distance memory,
// then the walk back onto the cycle, the collection of its vertices and the
// delivery of the first result item, the items between and the closing one.
// Reset is synchronous and needs no clearing pass. A stalled
// m_ready holds the output register and the search waits for it.
// ----------------------------------------------------------------------------
module negative_cycle_finder_unit #(
    parameter int MAX_VERTICES = ncf_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = ncf_pkg::MAX_EDGES_DEF,
    parameter int DIST_WIDTH   = ncf_pkg::DIST_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Edge items.
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [ncf_pkg::VERTEX_W-1:0]         s_edge_source,
    input  logic [ncf_pkg::VERTEX_W-1:0]         s_edge_target,
    input  logic signed [ncf_pkg::WEIGHT_W-1:0]  s_edge_weight,
    input  logic                                 s_edge_last,
    // Result items.
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_cycle_found,
    output logic [ncf_pkg::VERTEX_W-1:0]         m_cycle_vertex,
    output logic                                 m_result_last,
    // Register port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ncf_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [ncf_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [ncf_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);

    logic [ncf_pkg::VCOUNT_W-1:0]  vertex_count_reg;
    logic                          reg_hit;
    ncf_pkg::ncf_cmd_t             cmd;
    ncf_pkg::ncf_status_t          status;

    // Register decode: only the word index matters.
    assign reg_hit = (paddr[ncf_pkg::APB_ADDR_W-1:2] == ncf_pkg::REG_VERTEX_COUNT);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? ncf_pkg::APB_DATA_W'(vertex_count_reg) : '0;

    // Vertex count register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= ncf_pkg::VCOUNT_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            vertex_count_reg <= pwdata[ncf_pkg::VCOUNT_W-1:0];
        end
    end

    ncf_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_edge_last (s_edge_last),
        .status      (status),
        .s_ready     (s_ready),
        .cmd         (cmd)
    );

    ncf_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .DIST_WIDTH   (DIST_WIDTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .vertex_count   (vertex_count_reg),
        .s_edge_source  (s_edge_source),
        .s_edge_target  (s_edge_target),
        .s_edge_weight  (s_edge_weight),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_cycle_found  (m_cycle_found),
        .m_cycle_vertex (m_cycle_vertex),
        .m_result_last  (m_result_last)
    );

    // A last edge starts a search, so no edge is taken in the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_edge_last) |=> !s_ready)
        else $error("edge taken while a search was starting");

    // A not-found result is always a single closing item with vertex zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_cycle_found) |-> (m_result_last && (m_cycle_vertex == '0)))
        else $error("malformed not-found result");

    // The output register is never overwritten while it still holds a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("result item overwritten before it was taken");

endmodule

/* hdl/ncf_ctrl.sv */
// ----------------------------------------------------------------------------
// ncf_ctrl: sequencing controller
// Steps the datapath through edge loading, the relaxation and check passes,
// the walk back onto the cycle, the collection of its vertices and the
// delivery of the result items.
// ----------------------------------------------------------------------------
module ncf_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_edge_last,
    input  ncf_pkg::ncf_status_t status,
    output logic                 s_ready,
    output ncf_pkg::ncf_cmd_t    cmd
);

    ncf_pkg::ncf_state_t state_reg;
    ncf_pkg::ncf_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ncf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Edges are taken only while no search is in progress.
    assign s_ready = (state_reg == ncf_pkg::ST_IDLE);

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ncf_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_edge = 1'b1;
                    if (s_edge_last) begin
                        cmd.run_init = 1'b1;
                        state_next   = ncf_pkg::ST_START;
                    end
                end
            end
            ncf_pkg::ST_START: begin
                state_next = status.total_zero ? ncf_pkg::ST_EMIT_NONE : ncf_pkg::ST_EDGE_RD;
            end
            ncf_pkg::ST_EDGE_RD: begin
                state_next = ncf_pkg::ST_EDGE_DEC;
            end
            ncf_pkg::ST_EDGE_DEC: begin
                state_next = ncf_pkg::ST_EDGE_ADD;
            end
            ncf_pkg::ST_EDGE_ADD: begin
                state_next = ncf_pkg::ST_EDGE_CMP;
            end
            ncf_pkg::ST_EDGE_CMP: begin
                if (status.relax && status.check_phase) begin
                    cmd.found_capture = 1'b1;
                    state_next        = ncf_pkg::ST_WALK_RD;
                end else begin
                    cmd.relax_write = status.relax;
                    cmd.edge_next   = 1'b1;
                    if (status.check_phase && status.last_edge) begin
                        state_next = ncf_pkg::ST_EMIT_NONE;
                    end else begin
                        state_next = ncf_pkg::ST_EDGE_RD;
                    end
                end
            end
            ncf_pkg::ST_WALK_RD: begin
                state_next = ncf_pkg::ST_WALK_STEP;
            end
            ncf_pkg::ST_WALK_STEP: begin
                cmd.walk_step = 1'b1;
                if (status.walk_last) begin
                    cmd.walk_close = 1'b1;
                    state_next     = ncf_pkg::ST_COL_RD;
                end else begin
                    state_next = ncf_pkg::ST_WALK_RD;
                end
            end
            ncf_pkg::ST_COL_RD: begin
                cmd.col_write = 1'b1;
                state_next    = ncf_pkg::ST_COL_CHK;
            end
            ncf_pkg::ST_COL_CHK: begin
                cmd.col_next = 1'b1;
                state_next   = status.col_done ? ncf_pkg::ST_EMIT_FIRST : ncf_pkg::ST_COL_RD;
            end
            ncf_pkg::ST_EMIT_FIRST: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = ncf_pkg::OUT_START;
                    cmd.cnt_dec  = 1'b1;
                    state_next   = status.len_one ? ncf_pkg::ST_EMIT_END : ncf_pkg::ST_BUF_RD;
                end
            end
            ncf_pkg::ST_BUF_RD: begin
                state_next = ncf_pkg::ST_BUF_OUT;
            end
            ncf_pkg::ST_BUF_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = ncf_pkg::OUT_BUF;
                    cmd.cnt_dec  = 1'b1;
                    state_next   = status.len_one ? ncf_pkg::ST_EMIT_END : ncf_pkg::ST_BUF_RD;
                end
            end
            ncf_pkg::ST_EMIT_END: begin
                if (status.out_free) begin
                    cmd.out_load    = 1'b1;
                    cmd.out_kind    = ncf_pkg::OUT_CLOSE;
                    cmd.total_clear = 1'b1;
                    state_next      = ncf_pkg::ST_IDLE;
                end
            end
            ncf_pkg::ST_EMIT_NONE: begin
                if (status.out_free) begin
                    cmd.out_load    = 1'b1;
                    cmd.out_kind    = ncf_pkg::OUT_NONE;
                    cmd.total_clear = 1'b1;
                    state_next      = ncf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ncf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/ncf_datapath.sv */
// ----------------------------------------------------------------------------
// ncf_datapath: edge store, distance and predecessor memories, counters
// Holds the stored graph, the per-vertex distances and predecessors, the
// cycle buffer and the output register, and reports status to the controller.
// ----------------------------------------------------------------------------
module ncf_datapath #(
    parameter int MAX_VERTICES = ncf_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = ncf_pkg::MAX_EDGES_DEF,
    parameter int DIST_WIDTH   = ncf_pkg::DIST_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  ncf_pkg::ncf_cmd_t                    cmd,
    output ncf_pkg::ncf_status_t                 status,
    input  logic [ncf_pkg::VCOUNT_W-1:0]         vertex_count,
    input  logic [ncf_pkg::VERTEX_W-1:0]         s_edge_source,
    input  logic [ncf_pkg::VERTEX_W-1:0]         s_edge_target,
    input  logic signed [ncf_pkg::WEIGHT_W-1:0]  s_edge_weight,
    input  logic                                 m_ready,
    output logic                                 m_valid,
    output logic                                 m_cycle_found,
    output logic [ncf_pkg::VERTEX_W-1:0]         m_cycle_vertex,
    output logic                                 m_result_last
);

    localparam int VIDX_W = $clog2(MAX_VERTICES);
    localparam int VC_W   = $clog2(MAX_VERTICES + 1);
    localparam int EIDX_W = $clog2(MAX_EDGES);
    localparam int ECNT_W = $clog2(MAX_EDGES + 1);
    localparam int VEXT_W = (VIDX_W > ncf_pkg::VERTEX_W) ? VIDX_W : ncf_pkg::VERTEX_W;
    localparam int SUM_W  = DIST_WIDTH + 1;
    localparam int VW     = ncf_pkg::VERTEX_W;
    localparam int EW     = ncf_pkg::EDGE_W;

    // Counters and run state.
    logic [ECNT_W-1:0] edge_total_reg;
    logic [EIDX_W-1:0] edge_idx_reg;
    logic [VC_W-1:0]   pass_reg;
    logic [VC_W-1:0]   vc_reg;
    logic [VC_W-1:0]   cnt_reg;
    logic [VW-1:0]     cur_reg;
    logic [VW-1:0]     start_reg;

    // Memories and their registered read data.
    logic [EW-1:0]                edge_mem [MAX_EDGES];
    logic [EW-1:0]                edge_rd_reg;
    logic signed [DIST_WIDTH-1:0] dist_mem [MAX_VERTICES];
    logic signed [DIST_WIDTH-1:0] dist_u_reg;
    logic signed [DIST_WIDTH-1:0] dist_v_reg;
    logic [MAX_VERTICES-1:0]      dist_valid_reg;
    logic                         du_valid_reg;
    logic                         dv_valid_reg;
    logic [VW-1:0]                pred_mem [MAX_VERTICES];
    logic [VW-1:0]                pred_rd_reg;
    logic [MAX_VERTICES-1:0]      pred_valid_reg;
    logic                         pv_valid_reg;
    logic [VW-1:0]                buf_mem [MAX_VERTICES];
    logic [VW-1:0]                buf_rd_reg;

    // Relaxation arithmetic.
    logic signed [DIST_WIDTH-1:0] nd_reg;
    logic                         in_range_reg;

    // Output register.
    logic          m_valid_reg;
    logic          found_reg;
    logic [VW-1:0] vertex_reg;
    logic          last_reg;

    // Combinational helpers.
    logic                         keep_edge;
    logic [VC_W-1:0]              vc_clamp;
    logic [VW-1:0]                rd_u;
    logic [VW-1:0]                rd_v;
    logic signed [ncf_pkg::WEIGHT_W-1:0] rd_w;
    logic [VEXT_W-1:0]            u_ext;
    logic [VEXT_W-1:0]            v_ext;
    logic [VEXT_W-1:0]            cur_ext;
    logic [VIDX_W-1:0]            u_idx;
    logic [VIDX_W-1:0]            v_idx;
    logic [VIDX_W-1:0]            cur_idx;
    logic [VIDX_W-1:0]            cnt_idx;
    logic signed [DIST_WIDTH-1:0] dist_u_val;
    logic signed [DIST_WIDTH-1:0] dist_v_val;
    logic signed [SUM_W-1:0]      sum_full;
    logic signed [DIST_WIDTH-1:0] nd;
    logic [VW-1:0]                pred_val;

    // An edge is kept when its weight is in range and the store has room.
    assign keep_edge = (int'(s_edge_weight) > -ncf_pkg::MISSING_LIMIT)
                    && (int'(s_edge_weight) < ncf_pkg::MISSING_LIMIT)
                    && (edge_total_reg != ECNT_W'(MAX_EDGES));

    // Vertex count in force for the run, clamped to the supported range.
    always_comb begin
        if (vertex_count == '0) begin
            vc_clamp = VC_W'(1);
        end else if (int'(vertex_count) > MAX_VERTICES) begin
            vc_clamp = VC_W'(MAX_VERTICES);
        end else begin
            vc_clamp = VC_W'(vertex_count);
        end
    end

    // Fields of the edge under test and the memory indexes taken from them.
    assign rd_u    = edge_rd_reg[VW-1:0];
    assign rd_v    = edge_rd_reg[2*VW-1:VW];
    assign rd_w    = $signed(edge_rd_reg[EW-1:2*VW]);
    assign u_ext   = VEXT_W'(rd_u);
    assign v_ext   = VEXT_W'(rd_v);
    assign cur_ext = VEXT_W'(cur_reg);
    assign u_idx   = u_ext[VIDX_W-1:0];
    assign v_idx   = v_ext[VIDX_W-1:0];
    assign cur_idx = cur_ext[VIDX_W-1:0];
    assign cnt_idx = cnt_reg[VIDX_W-1:0];

    // Entries not yet written in this run read as zero.
    assign dist_u_val = du_valid_reg ? dist_u_reg : '0;
    assign dist_v_val = dv_valid_reg ? dist_v_reg : '0;
    assign pred_val   = pv_valid_reg ? pred_rd_reg : '0;

    // Saturating sum: distances never rise above zero, so only the floor can be crossed.
    assign sum_full = $signed(SUM_W'(dist_u_val)) + $signed(SUM_W'(rd_w));
    always_comb begin
        if (sum_full[SUM_W-1] != sum_full[SUM_W-2]) begin
            nd = {1'b1, {(DIST_WIDTH-1){1'b0}}};
        end else begin
            nd = sum_full[DIST_WIDTH-1:0];
        end
    end

    // Edge store: written on load, read at the current edge index.
    always_ff @(posedge aclk) begin
        if (cmd.load_edge && keep_edge) begin
            edge_mem[edge_total_reg[EIDX_W-1:0]] <= {s_edge_weight, s_edge_target, s_edge_source};
        end
        edge_rd_reg <= edge_mem[edge_idx_reg];
    end

    // Distance memory: two reads, one write on relaxation.
    always_ff @(posedge aclk) begin
        if (cmd.relax_write) begin
            dist_mem[v_idx] <= nd_reg;
        end
        dist_u_reg   <= dist_mem[u_idx];
        dist_v_reg   <= dist_mem[v_idx];
        du_valid_reg <= dist_valid_reg[u_idx];
        dv_valid_reg <= dist_valid_reg[v_idx];
    end

    // Predecessor memory: written on relaxation, read at the walk vertex.
    always_ff @(posedge aclk) begin
        if (cmd.relax_write) begin
            pred_mem[v_idx] <= rd_u;
        end
        pred_rd_reg  <= pred_mem[cur_idx];
        pv_valid_reg <= pred_valid_reg[cur_idx];
    end

    // Cycle buffer: filled during collection, read back in reverse.
    always_ff @(posedge aclk) begin
        if (cmd.col_write) begin
            buf_mem[cnt_idx] <= cur_reg;
        end
        buf_rd_reg <= buf_mem[cnt_idx];
    end

    // Candidate distance and range check of the edge under test.
    always_ff @(posedge aclk) begin
        nd_reg       <= nd;
        in_range_reg <= (32'(rd_u) < 32'(vc_reg)) && (32'(rd_v) < 32'(vc_reg));
    end

    // Valid bits of the distance and predecessor memories.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_valid_reg <= '0;
            pred_valid_reg <= '0;
        end else if (cmd.run_init) begin
            dist_valid_reg <= '0;
            pred_valid_reg <= '0;
        end else if (cmd.relax_write) begin
            dist_valid_reg[v_idx] <= 1'b1;
            pred_valid_reg[v_idx] <= 1'b1;
        end
    end

    // Edge count, pass and edge position, and the shared step counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_total_reg <= '0;
            edge_idx_reg   <= '0;
            pass_reg       <= '0;
            vc_reg         <= VC_W'(1);
            cnt_reg        <= '0;
        end else begin
            if (cmd.total_clear) begin
                edge_total_reg <= '0;
            end else if (cmd.load_edge && keep_edge) begin
                edge_total_reg <= edge_total_reg + ECNT_W'(1);
            end
            if (cmd.run_init) begin
                edge_idx_reg <= '0;
                pass_reg     <= '0;
                vc_reg       <= vc_clamp;
            end else if (cmd.edge_next) begin
                if (status.last_edge) begin
                    edge_idx_reg <= '0;
                    pass_reg     <= pass_reg + VC_W'(1);
                end else begin
                    edge_idx_reg <= edge_idx_reg + EIDX_W'(1);
                end
            end
            if (cmd.found_capture || cmd.walk_close) begin
                cnt_reg <= '0;
            end else if (cmd.walk_step || cmd.col_write) begin
                cnt_reg <= cnt_reg + VC_W'(1);
            end else if (cmd.cnt_dec) begin
                cnt_reg <= cnt_reg - VC_W'(1);
            end
        end
    end

    // Walk and collection vertices.
    always_ff @(posedge aclk) begin
        if (cmd.found_capture) begin
            cur_reg <= rd_v;
        end else if (cmd.walk_step || cmd.col_next) begin
            cur_reg <= pred_val;
        end
        if (cmd.walk_close) begin
            start_reg <= pred_val;
        end
    end

    // Output register: a new result is loaded only once the previous one has gone.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            case (cmd.out_kind)
                ncf_pkg::OUT_START: begin
                    found_reg  <= 1'b1;
                    vertex_reg <= start_reg;
                    last_reg   <= 1'b0;
                end
                ncf_pkg::OUT_BUF: begin
                    found_reg  <= 1'b1;
                    vertex_reg <= buf_rd_reg;
                    last_reg   <= 1'b0;
                end
                ncf_pkg::OUT_CLOSE: begin
                    found_reg  <= 1'b1;
                    vertex_reg <= start_reg;
                    last_reg   <= 1'b1;
                end
                default: begin
                    found_reg  <= 1'b0;
                    vertex_reg <= '0;
                    last_reg   <= 1'b1;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_cycle_found  = found_reg;
    assign m_cycle_vertex = vertex_reg;
    assign m_result_last  = last_reg;

    // Status to the controller.
    assign status.total_zero  = (edge_total_reg == '0);
    assign status.relax       = in_range_reg && (nd_reg < dist_v_val);
    assign status.last_edge   = ((ECNT_W'(edge_idx_reg) + ECNT_W'(1)) == edge_total_reg);
    assign status.check_phase = (pass_reg == vc_reg);
    assign status.walk_last   = ((cnt_reg + VC_W'(1)) == vc_reg);
    assign status.col_done    = (pred_val == start_reg) || (cnt_reg == vc_reg);
    assign status.len_one     = (cnt_reg == VC_W'(1));
    assign status.out_free    = !m_valid_reg || m_ready;

endmodule
